>>> rtl/prs_pkg.sv
package prs_pkg;

  // Event codes carried on the func field
  typedef enum logic [2:0] {
    FUNC_CREATE    = 3'd0,
    FUNC_DELAY     = 3'd1,
    FUNC_SUSPEND   = 3'd2,
    FUNC_RESUME    = 3'd3,
    FUNC_START     = 3'd4,
    FUNC_INT_ENTER = 3'd5,
    FUNC_INT_EXIT  = 3'd6,
    FUNC_NOP       = 3'd7
  } func_t;

  // Switch report codes
  typedef enum logic [1:0] {
    SW_NONE  = 2'd0,
    SW_TASK  = 2'd1,
    SW_INT   = 2'd2,
    SW_START = 2'd3
  } switch_kind_t;

  localparam int unsigned MAP_W   = 32;
  localparam int unsigned PRIO_W  = 5;
  localparam int unsigned DEPTH_W = 8;

  localparam logic [MAP_W-1:0]   ONLY_TOP_BIT = 32'h8000_0000;
  localparam logic [PRIO_W-1:0]  TOP_PRIO     = 5'd31;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX    = 8'd255;

endpackage

>>> rtl/priority_ready_scheduler_top.sv
// An accepted input beat reaches its result beat through the input register,
// then the scheduling logic feeding the result register.
// Throughput: one event per cycle while out_ready is high; the ready-map update
// and the 32-bit priority encoder sit between the input and result registers.
// Reset (rst_n low, synchronous): ready map, priorities, started flag and
// nesting count clear to zero and both pipeline registers empty.
module priority_ready_scheduler_top #(
  parameter int unsigned TASKS     = 32,
  parameter int unsigned IDLE_PRIO = 31
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [4:0]  in_task_prio,
  input  logic [31:0] in_delay_ticks,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_switch_kind,
  output logic [4:0]  out_from_prio,
  output logic [4:0]  out_to_prio,
  output logic [4:0]  out_current_prio,
  output logic [7:0]  out_nesting_depth
);

  // Bits of the map that belong to real tasks
  localparam logic [32:0] MASK_WIDE = (33'd1 << TASKS) - 33'd1;
  localparam logic [31:0] TASK_MASK = MASK_WIDE[31:0];
  localparam logic [4:0]  IDLE_P    = IDLE_PRIO[4:0];
  localparam logic        IDLE_OK   = (IDLE_PRIO < TASKS);

  // Input register
  logic                in_valid_r;
  prs_pkg::func_t      in_func_r;
  logic [4:0]          in_prio_r;
  logic                in_ticks_nz_r;

  // Scheduler state
  logic [31:0]         ready_map_r,   ready_map_nxt;
  logic [4:0]          running_r,     running_nxt;
  logic [4:0]          best_r,        best_nxt;
  logic                started_r,     started_nxt;
  logic [7:0]          depth_r,       depth_nxt;

  // Result register
  logic                out_valid_r;
  prs_pkg::switch_kind_t out_kind_r,  kind_nxt;
  logic [4:0]          out_from_r,    from_nxt;
  logic [4:0]          out_to_r,      to_nxt;
  logic [4:0]          out_cur_r;
  logic [7:0]          out_depth_r;

  logic                process;
  logic [31:0]         scan;
  logic [4:0]          enc;
  logic [4:0]          best_found;

  // Work on the held beat whenever the result slot is free or draining
  assign process  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || process;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_func_r     <= prs_pkg::func_t'(in_func);
      in_prio_r     <= in_task_prio;
      in_ticks_nz_r <= |in_delay_ticks;
    end
  end

  // Ready-map update for the held beat
  always_comb begin
    ready_map_nxt = ready_map_r;
    unique case (in_func_r)
      prs_pkg::FUNC_CREATE: begin
        if (TASK_MASK[in_prio_r]) ready_map_nxt[in_prio_r] = 1'b1;
      end
      prs_pkg::FUNC_DELAY: begin
        if (in_ticks_nz_r) ready_map_nxt[running_r] = 1'b0;
      end
      prs_pkg::FUNC_SUSPEND: begin
        ready_map_nxt[in_prio_r] = 1'b0;
      end
      prs_pkg::FUNC_RESUME: begin
        ready_map_nxt[in_prio_r] = 1'b1;
      end
      prs_pkg::FUNC_START: begin
        if (!started_r && IDLE_OK) ready_map_nxt[IDLE_P] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Highest-ready search over the updated map: lowest set task bit wins
  assign scan = ready_map_nxt & TASK_MASK;
  always_comb begin
    enc = '0;
    for (int i = 31; i >= 0; i--) begin
      if (scan[i]) enc = i[4:0];
    end
  end

  always_comb begin
    if (ready_map_nxt == prs_pkg::ONLY_TOP_BIT) begin
      best_found = prs_pkg::TOP_PRIO;
    end else if (|scan) begin
      best_found = enc;
    end else begin
      best_found = best_r;
    end
  end

  // Event decode and schedule
  always_comb begin
    logic sched;
    prs_pkg::switch_kind_t sched_kind;
    sched         = 1'b0;
    sched_kind    = prs_pkg::SW_TASK;
    running_nxt   = running_r;
    best_nxt      = best_r;
    started_nxt   = started_r;
    depth_nxt     = depth_r;
    kind_nxt      = prs_pkg::SW_NONE;
    from_nxt      = '0;
    to_nxt        = '0;

    unique case (in_func_r)
      prs_pkg::FUNC_DELAY: begin
        sched = in_ticks_nz_r;
      end
      prs_pkg::FUNC_SUSPEND: begin
        sched = (running_r == in_prio_r);
      end
      prs_pkg::FUNC_RESUME: begin
        sched = (running_r > in_prio_r);
      end
      prs_pkg::FUNC_START: begin
        if (!started_r) started_nxt = 1'b1;
      end
      prs_pkg::FUNC_INT_ENTER: begin
        if (depth_r != prs_pkg::DEPTH_MAX) depth_nxt = depth_r + 8'd1;
      end
      prs_pkg::FUNC_INT_EXIT: begin
        if (depth_r != 8'd0) depth_nxt = depth_r - 8'd1;
        sched      = (depth_nxt == 8'd0);
        sched_kind = prs_pkg::SW_INT;
      end
      default: begin
      end
    endcase

    // First start always reports, even with no priority change
    if (in_func_r == prs_pkg::FUNC_START && !started_r) begin
      best_nxt    = best_found;
      running_nxt = best_found;
      kind_nxt    = prs_pkg::SW_START;
      to_nxt      = best_found;
    end else if (sched) begin
      best_nxt = best_found;
      if (best_found != running_r) begin
        running_nxt = best_found;
        kind_nxt    = sched_kind;
        from_nxt    = running_r;
        to_nxt      = best_found;
      end
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_map_r <= '0;
      running_r   <= '0;
      best_r      <= '0;
      started_r   <= 1'b0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (process) begin
        ready_map_r <= ready_map_nxt;
        running_r   <= running_nxt;
        best_r      <= best_nxt;
        started_r   <= started_nxt;
        depth_r     <= depth_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (process) begin
      out_kind_r  <= kind_nxt;
      out_from_r  <= from_nxt;
      out_to_r    <= to_nxt;
      out_cur_r   <= running_nxt;
      out_depth_r <= depth_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_switch_kind   = out_kind_r;
  assign out_from_prio     = out_from_r;
  assign out_to_prio       = out_to_r;
  assign out_current_prio  = out_cur_r;
  assign out_nesting_depth = out_depth_r;

  // A reported switch always lands on the running priority
  a_to_is_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != prs_pkg::SW_NONE |-> out_to_r == out_cur_r)
    else $error("switch target differs from running priority");

  // No switch reports no priorities
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == prs_pkg::SW_NONE |-> out_to_r == 5'd0 && out_from_r == 5'd0)
    else $error("idle result carries priorities");

  // Running priority only moves when a switch is reported
  a_run_moves_on_switch: assert property (@(posedge clk) disable iff (!rst_n)
    process && kind_nxt == prs_pkg::SW_NONE |=> running_r == $past(running_r))
    else $error("running priority changed without a switch");

  // Nesting count moves by at most one per beat
  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    process |=> depth_r == $past(depth_r) || depth_r == $past(depth_r) + 8'd1 ||
                depth_r == $past(depth_r) - 8'd1)
    else $error("nesting count jumped");

  // An empty input register always takes a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input stalled while empty");

endmodule
